@@ rtl/brbo_pkg.sv @@
// ----------------------------------------------------------------------------
// brbo_pkg
// Shared constants, command codes and types for the byte ring buffer.
// ----------------------------------------------------------------------------
package brbo_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SIZE_W   = ADDR_W + 1;
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 8;
    localparam int AMOUNT_W = 10;
    localparam int FILL_W   = 10;
    localparam int RING_W   = 11;

    // working width for index arithmetic, wide enough for any operand sum
    localparam int MAX_W  = (SIZE_W > AMOUNT_W) ?
                            ((SIZE_W > RING_W) ? SIZE_W : RING_W) :
                            ((AMOUNT_W > RING_W) ? AMOUNT_W : RING_W);
    localparam int CALC_W = MAX_W + 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH      = 3'd0,
        CMD_POP       = 3'd1,
        CMD_PEEK_HEAD = 3'd2,
        CMD_PEEK_TAIL = 3'd3,
        CMD_SET_LEN   = 3'd4,
        CMD_RESET     = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [DATA_W-1:0]   data_in;
        logic [AMOUNT_W-1:0] amount;
    } item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              read_ok;
        logic [FILL_W-1:0] fill_level;
        logic              overwrote;
    } meta_t;

endpackage

@@ rtl/brbo_if.sv @@
// ----------------------------------------------------------------------------
// brbo_if
// Valid/ready channels for command words, result words and configuration.
// ----------------------------------------------------------------------------
interface brbo_item_if;
    logic                           valid;
    logic                           ready;
    logic [brbo_pkg::CMD_W-1:0]     cmd;
    logic [brbo_pkg::DATA_W-1:0]    data_in;
    logic [brbo_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, output cmd, output data_in, output amount, input ready);
    modport sink   (input valid, input cmd, input data_in, input amount, output ready);
endinterface

interface brbo_result_if;
    logic                          valid;
    logic                          ready;
    logic [brbo_pkg::DATA_W-1:0]   read_byte;
    logic                          read_ok;
    logic [brbo_pkg::FILL_W-1:0]   fill_level;
    logic                          overwrote;

    modport source (output valid, output read_byte, output read_ok, output fill_level,
                    output overwrote, input ready);
    modport sink   (input valid, input read_byte, input read_ok, input fill_level,
                    input overwrote, output ready);
endinterface

interface brbo_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [brbo_pkg::RING_W-1:0]   ring_size;

    modport source (output valid, output ring_size, input ready);
    modport sink   (input valid, input ring_size, output ready);
endinterface

@@ rtl/brbo_ram.sv @@
// ----------------------------------------------------------------------------
// brbo_ram
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brbo_ram
(
    input  logic                              clk,
    input  brbo_pkg::ram_req_t                req,
    output logic [brbo_pkg::DATA_W-1:0]       rdata
);

    logic [brbo_pkg::DATA_W-1:0] mem [brbo_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

@@ rtl/brbo_ptr.sv @@
// ----------------------------------------------------------------------------
// brbo_ptr
// Ring size, head/tail pointers and fill count; decodes one command word
// into a store access and result flags.
// ----------------------------------------------------------------------------
module brbo_ptr
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [brbo_pkg::RING_W-1:0]      cfg_data,
    input  logic                             fire,
    input  brbo_pkg::item_t                  item,
    output brbo_pkg::ram_req_t               req,
    output brbo_pkg::meta_t                  meta
);

    localparam int W = brbo_pkg::CALC_W;
    localparam int AW = brbo_pkg::ADDR_W;

    logic [brbo_pkg::SIZE_W-1:0] size_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] fill_reg, fill_next;

    logic [W-1:0] sz, hd, tl, fl, amt, cv;
    logic [W-1:0] size_clamped;
    logic [W-1:0] tail_inc, head_inc, hsum, tback, amt_sat, lsum;
    logic         full, empty, in_range;
    logic         we_c, re_c, ok_c, ovw_c;
    logic [AW-1:0] raddr_c;

    always_comb
    begin
        cv = W'(cfg_data);
        if (cv < W'(2))
        begin
            size_clamped = W'(2);
        end
        else if (cv > W'(brbo_pkg::DEPTH))
        begin
            size_clamped = W'(brbo_pkg::DEPTH);
        end
        else
        begin
            size_clamped = cv;
        end
    end

    always_comb
    begin
        sz  = W'(size_reg);
        hd  = W'(head_reg);
        tl  = W'(tail_reg);
        fl  = W'(fill_reg);
        amt = W'(item.amount);

        tail_inc = tl + W'(1);
        if (tail_inc == sz)
        begin
            tail_inc = '0;
        end
        head_inc = hd + W'(1);
        if (head_inc == sz)
        begin
            head_inc = '0;
        end

        hsum = hd + amt;
        if (hsum >= sz)
        begin
            hsum = hsum - sz;
        end

        // offset 0 is the newest byte
        tback = tl + sz - amt - W'(1);
        if (tback >= sz)
        begin
            tback = tback - sz;
        end

        amt_sat = (amt > sz - W'(1)) ? sz - W'(1) : amt;
        lsum = hd + amt_sat;
        if (lsum >= sz)
        begin
            lsum = lsum - sz;
        end

        full     = (fl == sz - W'(1));
        empty    = (fl == '0);
        in_range = (amt < fl);

        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        we_c      = 1'b0;
        re_c      = 1'b0;
        ok_c      = 1'b0;
        ovw_c     = 1'b0;
        raddr_c   = head_reg;

        unique case (item.cmd)
            brbo_pkg::CMD_PUSH:
            begin
                we_c      = 1'b1;
                tail_next = AW'(tail_inc);
                if (full)
                begin
                    head_next = AW'(head_inc);
                    ovw_c     = 1'b1;
                end
                else
                begin
                    fill_next = AW'(fl + W'(1));
                end
            end
            brbo_pkg::CMD_POP:
            begin
                if (!empty)
                begin
                    re_c      = 1'b1;
                    ok_c      = 1'b1;
                    head_next = AW'(head_inc);
                    fill_next = AW'(fl - W'(1));
                end
            end
            brbo_pkg::CMD_PEEK_HEAD:
            begin
                if (in_range)
                begin
                    re_c    = 1'b1;
                    ok_c    = 1'b1;
                    raddr_c = AW'(hsum);
                end
            end
            brbo_pkg::CMD_PEEK_TAIL:
            begin
                if (in_range)
                begin
                    re_c    = 1'b1;
                    ok_c    = 1'b1;
                    raddr_c = AW'(tback);
                end
            end
            brbo_pkg::CMD_SET_LEN:
            begin
                tail_next = AW'(lsum);
                fill_next = AW'(amt_sat);
            end
            brbo_pkg::CMD_RESET:
            begin
                head_next = '0;
                tail_next = '0;
                fill_next = '0;
            end
            default:
            begin
            end
        endcase

        req.we    = fire && we_c;
        req.waddr = tail_reg;
        req.wdata = item.data_in;
        req.re    = fire && re_c;
        req.raddr = raddr_c;

        meta.read_ok    = ok_c;
        meta.fill_level = brbo_pkg::FILL_W'(fill_next);
        meta.overwrote  = ovw_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= brbo_pkg::SIZE_W'(brbo_pkg::DEPTH);
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else if (cfg_we)
        begin
            size_reg <= brbo_pkg::SIZE_W'(size_clamped);
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else if (fire)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        W'(fill_reg) < W'(size_reg))
        else $error("fill count reached ring size");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        W'(head_reg) < W'(size_reg) && W'(tail_reg) < W'(size_reg))
        else $error("pointer outside ring");

    a_fill_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        ((W'(tail_reg) >= W'(head_reg)) ?
            (W'(tail_reg) - W'(head_reg)) :
            (W'(tail_reg) + W'(size_reg) - W'(head_reg))) == W'(fill_reg))
        else $error("fill count disagrees with pointers");

    a_overwrite_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ovw_c && !cfg_we |=> W'(fill_reg) == W'(size_reg) - W'(1))
        else $error("overwrite left queue not full");
`endif

endmodule

@@ rtl/byte_ring_buffer_overwrite_oldest.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite_oldest
// Circular byte queue that drops its oldest byte when pushed while full.
// ----------------------------------------------------------------------------
// One command word is accepted per cycle, sustained while results are taken, and each
// gives exactly one result word, through the input register and then the result
// register. The rate is set by the single byte-store access at most (one write or one
// read) that each word needs, which the 1024 x 8 store serves every cycle. An input
// register in front of the core lets a word be taken while a result waits. A
// write to ring_size empties the queue; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite_oldest
(
    input  logic            clk,
    input  logic            rst_n,
    brbo_cfg_if.sink        cfg,
    brbo_item_if.sink       item,
    brbo_result_if.source   result
);

    brbo_pkg::item_t    item_reg, item_next;
    logic               item_valid_reg, item_valid_next;
    brbo_pkg::meta_t    meta_reg, meta_next;
    logic               out_valid_reg, out_valid_next;
    logic               advance, load;
    brbo_pkg::ram_req_t req;
    logic [brbo_pkg::DATA_W-1:0] rdata;

    assign cfg.ready  = 1'b1;
    assign advance    = item_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign load       = item.valid && item.ready;

    always_comb
    begin
        item_next.cmd     = item.cmd;
        item_next.data_in = item.data_in;
        item_next.amount  = item.amount;
        item_valid_next   = load ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        out_valid_next    = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    brbo_ptr u_ptr
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.ring_size),
        .fire     (advance),
        .item     (item_reg),
        .req      (req),
        .meta     (meta_next)
    );

    brbo_ram u_ram
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            meta_reg <= meta_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.read_byte  = meta_reg.read_ok ? rdata : '0;
    assign result.read_ok    = meta_reg.read_ok;
    assign result.fill_level = meta_reg.fill_level;
    assign result.overwrote  = meta_reg.overwrote;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the overwrite-oldest byte ring buffer. Command words
// go in through a valid/ready channel with random gaps, and result words are
// taken with random stalls. A built-in predictor of the queue checks every
// result field against the oldest pending expectation. Directed words cover
// the empty, full and out-of-range cases. Random traffic then runs over
// several ring_size settings, including the clamped extremes.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int PHASE_WORDS   = 93;
    localparam int REPORT_LIMIT  = 10;

    // command codes with no operation behind them
    localparam logic [brbo_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [brbo_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [brbo_pkg::DATA_W-1:0] read_byte;
        logic                        read_ok;
        logic [brbo_pkg::FILL_W-1:0] fill_level;
        logic                        overwrote;
    } ring_result_t;

    logic clk;
    logic rst_n;
    logic sink_ready = 1'b0;

    brbo_cfg_if    cfg_ch ();
    brbo_item_if   item_ch ();
    brbo_result_if res_ch ();

    assign res_ch.ready = sink_ready;

    byte_ring_buffer_overwrite_oldest dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    // predictor state
    logic [brbo_pkg::DATA_W-1:0] ring_bytes [brbo_pkg::DEPTH];
    bit                          ring_written [brbo_pkg::DEPTH];
    int                          head_ptr = 0;
    int                          tail_ptr = 0;
    logic [brbo_pkg::RING_W-1:0] ring_size_reg = 11'd1024;
    ring_result_t                expected_q [$];

    int errors = 0;
    int words_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int valid_reads = 0;
    int overwrites = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit src_idle = 1'b0;
    bit snk_idle = 1'b0;
    ring_result_t got_word;
    ring_result_t want_word;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic int ring_span();
        int s;
        s = int'(ring_size_reg);
        if (s < 2)
            s = 2;
        if (s > brbo_pkg::DEPTH)
            s = brbo_pkg::DEPTH;
        return s;
    endfunction

    function automatic int fill_now();
        int s;
        s = ring_span();
        return (tail_ptr + s - head_ptr) % s;
    endfunction

    // slot that a word reads, -1 when it reads nothing
    function automatic int read_slot(logic [brbo_pkg::CMD_W-1:0] c,
                                     logic [brbo_pkg::AMOUNT_W-1:0] a);
        int s;
        int f;
        int amt;
        s = ring_span();
        f = fill_now();
        amt = int'(a);
        case (c)
            brbo_pkg::CMD_POP:
                if (f != 0)
                    return head_ptr;
            brbo_pkg::CMD_PEEK_HEAD:
                if (amt < f)
                    return (head_ptr + amt) % s;
            brbo_pkg::CMD_PEEK_TAIL:
                if (amt < f)
                    return (tail_ptr + s - 1 - amt) % s;
            default:
                ;
        endcase
        return -1;
    endfunction

    function automatic ring_result_t apply_word(logic [brbo_pkg::CMD_W-1:0] c,
                                                logic [brbo_pkg::DATA_W-1:0] d,
                                                logic [brbo_pkg::AMOUNT_W-1:0] a);
        ring_result_t r;
        int s;
        int f;
        int slot;
        int amt;
        r = '0;
        s = ring_span();
        f = fill_now();
        slot = read_slot(c, a);
        amt = int'(a);
        if (slot >= 0)
        begin
            r.read_byte = ring_bytes[slot];
            r.read_ok = 1'b1;
        end
        case (c)
            brbo_pkg::CMD_PUSH:
            begin
                ring_bytes[tail_ptr] = d;
                ring_written[tail_ptr] = 1'b1;
                tail_ptr = (tail_ptr + 1) % s;
                if (f >= s - 1)
                begin
                    head_ptr = (head_ptr + 1) % s;
                    r.overwrote = 1'b1;
                end
            end
            brbo_pkg::CMD_POP:
                if (f != 0)
                    head_ptr = (head_ptr + 1) % s;
            brbo_pkg::CMD_SET_LEN:
            begin
                if (amt > s - 1)
                    amt = s - 1;
                tail_ptr = (head_ptr + amt) % s;
            end
            brbo_pkg::CMD_RESET:
            begin
                head_ptr = 0;
                tail_ptr = 0;
            end
            default:
                ;
        endcase
        r.fill_level = brbo_pkg::FILL_W'(fill_now());
        return r;
    endfunction

    function automatic int idle_cycles(bit busy);
        int r;
        if (!busy)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // a read of a never-written slot is turned into a push
    task automatic send_word(logic [brbo_pkg::CMD_W-1:0] c, logic [brbo_pkg::DATA_W-1:0] d,
                             logic [brbo_pkg::AMOUNT_W-1:0] a);
        int gap;
        int slot;
        gap = idle_cycles(src_idle);
        slot = read_slot(c, a);
        if (slot >= 0 && !ring_written[slot])
            c = brbo_pkg::CMD_PUSH;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.cmd     <= c;
        item_ch.data_in <= d;
        item_ch.amount  <= a;
        expected_q.push_back(apply_word(c, d, a));
        words_sent++;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic write_ring_size(logic [brbo_pkg::RING_W-1:0] v);
        item_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.ring_size <= v;
        cfg_ch.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        ring_size_reg = v;
        head_ptr = 0;
        tail_ptr = 0;
        cfg_writes++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got_word = {res_ch.read_byte, res_ch.read_ok, res_ch.fill_level,
                            res_ch.overwrote};
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("tb_top: unexpected word byte %02h ok %0b fill %0d ovw %0b",
                                 got_word.read_byte, got_word.read_ok,
                                 got_word.fill_level, got_word.overwrote);
                end
                else
                begin
                    want_word = expected_q.pop_front();
                    results_checked++;
                    if (want_word.read_ok)
                        valid_reads++;
                    if (want_word.overwrote)
                        overwrites++;
                    if (got_word.read_byte !== want_word.read_byte ||
                        got_word.read_ok !== want_word.read_ok ||
                        got_word.fill_level !== want_word.fill_level ||
                        got_word.overwrote !== want_word.overwrote)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("tb_top: mismatch at result %0d: byte %02h ok %0b ",
                                     results_checked, got_word.read_byte, got_word.read_ok,
                                     "fill %0d ovw %0b, ",
                                     got_word.fill_level, got_word.overwrote,
                                     "expected byte %02h ok %0b ",
                                     want_word.read_byte, want_word.read_ok,
                                     "fill %0d ovw %0b",
                                     want_word.fill_level, want_word.overwrote);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                sink_ready <= 1'b0;
            end
            else
            begin
                sink_ready <= 1'b1;
                stall_left = idle_cycles(snk_idle);
            end
        end
    end

    task automatic test_basic_ops();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        send_word(brbo_pkg::CMD_POP, 8'h00, 10'd0);
        send_word(brbo_pkg::CMD_PEEK_HEAD, 8'h00, 10'd0);
        send_word(brbo_pkg::CMD_PEEK_TAIL, 8'h00, 10'd0);
        send_word(brbo_pkg::CMD_PUSH, 8'h00, 10'd0);
        send_word(brbo_pkg::CMD_PUSH, 8'hFF, 10'd1023);
        send_word(brbo_pkg::CMD_PUSH, 8'hA5, 10'd0);
        send_word(brbo_pkg::CMD_PEEK_HEAD, 8'h00, 10'd0);
        send_word(brbo_pkg::CMD_PEEK_HEAD, 8'h00, 10'd2);
        send_word(brbo_pkg::CMD_PEEK_HEAD, 8'h00, 10'd3);
        send_word(brbo_pkg::CMD_PEEK_TAIL, 8'h00, 10'd0);
        send_word(brbo_pkg::CMD_PEEK_TAIL, 8'h00, 10'd2);
        send_word(brbo_pkg::CMD_PEEK_TAIL, 8'h00, 10'd1023);
        send_word(brbo_pkg::CMD_POP, 8'h00, 10'd0);
        send_word(CMD_SPARE_6, 8'hFF, 10'd1023);
        send_word(CMD_SPARE_7, 8'h00, 10'd0);
    endtask

    task automatic test_full_overwrite();
        send_word(brbo_pkg::CMD_SET_LEN, 8'h00, 10'd1023);
        send_word(brbo_pkg::CMD_PUSH, 8'h5A, 10'd0);
        send_word(brbo_pkg::CMD_PEEK_TAIL, 8'h00, 10'd0);
        send_word(brbo_pkg::CMD_RESET, 8'h00, 10'd0);
    endtask

    task automatic test_smallest_ring();
        write_ring_size(11'd2);
        send_word(brbo_pkg::CMD_PUSH, 8'h3C, 10'd0);
        send_word(brbo_pkg::CMD_PUSH, 8'hC3, 10'd0);
        send_word(brbo_pkg::CMD_SET_LEN, 8'h00, 10'd1023);
        send_word(brbo_pkg::CMD_POP, 8'h00, 10'd0);
        send_word(brbo_pkg::CMD_PEEK_HEAD, 8'h00, 10'd0);
    endtask

    task automatic test_random_traffic();
        logic [brbo_pkg::RING_W-1:0] ring_sizes [11] = '{11'd3, 11'd0, 11'd1, 11'd2047,
                                                         11'd1025, 11'd5, 11'd16, 11'd100,
                                                         11'd700, 11'd1024, 11'd2};
        logic [brbo_pkg::CMD_W-1:0]    c;
        logic [brbo_pkg::DATA_W-1:0]   d;
        logic [brbo_pkg::AMOUNT_W-1:0] a;
        int r;
        int f;
        ring_sizes[10] = brbo_pkg::RING_W'($urandom_range(0, 2047));
        for (int p = 0; p < 11; p++)
        begin
            write_ring_size(ring_sizes[p]);
            src_idle = (p % 4 != 1);
            snk_idle = (p % 3 != 2);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                r = int'($urandom_range(0, 99));
                f = fill_now();
                if (r < 36)
                    c = brbo_pkg::CMD_PUSH;
                else if (r < 56)
                    c = brbo_pkg::CMD_POP;
                else if (r < 70)
                    c = brbo_pkg::CMD_PEEK_HEAD;
                else if (r < 84)
                    c = brbo_pkg::CMD_PEEK_TAIL;
                else if (r < 91)
                    c = brbo_pkg::CMD_SET_LEN;
                else if (r < 95)
                    c = brbo_pkg::CMD_RESET;
                else if (r < 98)
                    c = CMD_SPARE_6;
                else
                    c = CMD_SPARE_7;
                d = brbo_pkg::DATA_W'($urandom_range(0, 255));
                if ($urandom_range(0, 2) == 0)
                    a = brbo_pkg::AMOUNT_W'($urandom_range(0, 1023));
                else if (c == brbo_pkg::CMD_SET_LEN)
                    a = (f + 2 > 1023) ? brbo_pkg::AMOUNT_W'($urandom_range(0, 1023)) :
                                         brbo_pkg::AMOUNT_W'($urandom_range(0, f + 2));
                else
                    a = brbo_pkg::AMOUNT_W'($urandom_range(0, f));
                send_word(c, d, a);
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.ring_size <= '0;
        item_ch.valid    <= 1'b0;
        item_ch.cmd      <= '0;
        item_ch.data_in  <= '0;
        item_ch.amount   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_full_overwrite();
        test_smallest_ring();
        test_random_traffic();

        item_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d words sent over %0d ring_size settings, %0d results checked",
                 words_sent, cfg_writes, results_checked);
        $display("tb_top: %0d valid reads, %0d overwrites of the oldest byte, %0d mismatches",
                 valid_reads, overwrites, errors);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
